// ----- rtl/hfcp_pkg.sv -----
package hfcp_pkg;

    // Fixed field widths of the item ports
    localparam int MODE_W   = 2;
    localparam int SYM_W    = 6;
    localparam int BODY_W   = 64;

    // Defaults for the top-level parameters
    localparam int DEF_SYMBOL_COUNT = 64;
    localparam int DEF_RULE_DEPTH   = 64;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_FACT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RULE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PROVE = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic fact_wr;     // set the fact named by symbol
        logic rule_wr;     // append {symbol, body_mask} to the rule table
        logic query_ld;    // latch symbol as the query
        logic res_clear;   // pending result = proven 0, status 0
        logic res_hit;     // pending result proven = 1
        logic scan_start;  // start a pass: read rule 0, clear fired flag
        logic scan_step;   // evaluate the rule in the read register
        logic out_load;    // move pending result into the output register
    } hfcp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic qhit;         // query bit is a fact
        logic table_empty;  // no rules stored
        logic last_rule;    // read register holds the last stored rule
        logic fired_any;    // some rule fired in this pass, including this step
    } hfcp_stat_t;

endpackage

// ----- rtl/hfcp_datapath.sv -----
module hfcp_datapath #(
    parameter int SYMBOL_COUNT = hfcp_pkg::DEF_SYMBOL_COUNT,
    parameter int RULE_DEPTH   = hfcp_pkg::DEF_RULE_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hfcp_pkg::hfcp_cmd_t         cmd,
    output hfcp_pkg::hfcp_stat_t        stat,
    input  logic [hfcp_pkg::SYM_W-1:0]  symbol,
    input  logic [hfcp_pkg::BODY_W-1:0] body_mask,
    output logic                        proven,
    output logic                        status
);
    import hfcp_pkg::*;

    localparam int IDX_W  = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(RULE_DEPTH + 1);
    localparam int FIDX_W = $clog2(SYMBOL_COUNT);
    localparam int RULE_W = SYM_W + BODY_W;
    localparam logic [SYM_W:0]   SymLimit  = (SYM_W+1)'(SYMBOL_COUNT);
    localparam logic [CNT_W-1:0] DepthFull = CNT_W'(RULE_DEPTH);

    logic [SYMBOL_COUNT-1:0] fact_reg, fact_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [SYM_W-1:0]        query_reg;
    logic [IDX_W-1:0]        rd_idx_reg, rd_idx_next;
    logic [RULE_W-1:0]       rd_data_reg;
    logic                    fired_reg, fired_next;
    logic                    res_proven_reg, res_status_reg;
    logic                    proven_reg, status_reg;

    logic [RULE_W-1:0]       rule_mem [RULE_DEPTH];

    logic                    full;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic [SYM_W-1:0]        cur_head;
    logic [BODY_W-1:0]       cur_body;
    logic [BODY_W-1:0]       fact_ext;
    logic                    head_ok;
    logic                    fire_now;
    logic                    sym_ok;
    logic                    query_ok;

    assign full     = (cnt_reg == DepthFull);
    assign fact_ext = BODY_W'(fact_reg);
    assign cur_head = rd_data_reg[RULE_W-1:BODY_W];
    assign cur_body = rd_data_reg[BODY_W-1:0];

    assign sym_ok   = ({1'b0, symbol} < SymLimit);
    assign query_ok = ({1'b0, query_reg} < SymLimit);
    assign head_ok  = ({1'b0, cur_head} < SymLimit);

    // Body bits outside the symbol range read as never-true facts
    assign fire_now = head_ok && !fact_reg[cur_head[FIDX_W-1:0]]
                      && ((cur_body & ~fact_ext) == '0);

    assign stat.qhit        = query_ok && fact_reg[query_reg[FIDX_W-1:0]];
    assign stat.table_empty = (cnt_reg == '0);
    assign stat.last_rule   = (CNT_W'(rd_idx_reg) == (cnt_reg - CNT_W'(1)));
    assign stat.fired_any   = fired_reg || fire_now;

    assign rd_en   = cmd.scan_start || (cmd.scan_step && !stat.last_rule);
    assign rd_addr = cmd.scan_start ? '0 : (rd_idx_reg + IDX_W'(1));

    always_comb
    begin
        fact_next   = fact_reg;
        cnt_next    = cnt_reg;
        rd_idx_next = rd_idx_reg;
        fired_next  = fired_reg;
        if (cmd.fact_wr && sym_ok)
        begin
            fact_next[symbol[FIDX_W-1:0]] = 1'b1;
        end
        if (cmd.rule_wr && !full)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (rd_en)
        begin
            rd_idx_next = rd_addr;
        end
        if (cmd.scan_start)
        begin
            fired_next = 1'b0;
        end
        if (cmd.scan_step)
        begin
            fired_next = stat.fired_any;
            if (fire_now)
            begin
                fact_next[cur_head[FIDX_W-1:0]] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fact_reg   <= '0;
            cnt_reg    <= '0;
            rd_idx_reg <= '0;
            fired_reg  <= 1'b0;
        end
        else
        begin
            fact_reg   <= fact_next;
            cnt_reg    <= cnt_next;
            rd_idx_reg <= rd_idx_next;
            fired_reg  <= fired_next;
        end
    end

    // Rule table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.rule_wr && !full)
        begin
            rule_mem[cnt_reg[IDX_W-1:0]] <= {symbol, body_mask};
        end
        if (rd_en)
        begin
            rd_data_reg <= rule_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.query_ld)
        begin
            query_reg <= symbol;
        end
        if (cmd.res_clear)
        begin
            res_proven_reg <= 1'b0;
            res_status_reg <= 1'b0;
        end
        else if (cmd.rule_wr)
        begin
            res_proven_reg <= 1'b0;
            res_status_reg <= full;
        end
        else if (cmd.res_hit)
        begin
            res_proven_reg <= 1'b1;
        end
        if (cmd.out_load)
        begin
            proven_reg <= res_proven_reg;
            status_reg <= res_status_reg;
        end
    end

    assign proven = proven_reg;
    assign status = status_reg;

    a_no_fact_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> !cmd.fact_wr && !cmd.rule_wr)
        else $error("table or fact write during a rule scan");

    a_append_counts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rule_wr && !full |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("rule append did not advance the count");

    a_full_flags: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rule_wr && full |=> res_status_reg && cnt_reg == $past(cnt_reg))
        else $error("append to a full table not flagged");

endmodule

// ----- rtl/hfcp_ctrl.sv -----
module hfcp_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [hfcp_pkg::MODE_W-1:0] mode,
    output logic                        out_valid,
    input  logic                        out_ready,
    output hfcp_pkg::hfcp_cmd_t         cmd,
    input  hfcp_pkg::hfcp_stat_t        stat
);
    import hfcp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_PASS   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (mode)
                        MODE_FACT:
                        begin
                            cmd.fact_wr   = 1'b1;
                            cmd.res_clear = 1'b1;
                            state_next    = ST_RESULT;
                        end
                        MODE_RULE:
                        begin
                            cmd.rule_wr = 1'b1;
                            state_next  = ST_RESULT;
                        end
                        MODE_PROVE:
                        begin
                            cmd.query_ld  = 1'b1;
                            cmd.res_clear = 1'b1;
                            state_next    = ST_PASS;
                        end
                        default:
                        begin
                            cmd.res_clear = 1'b1;
                            state_next    = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_PASS:
            begin
                priority if (stat.qhit)
                begin
                    cmd.res_hit = 1'b1;
                    state_next  = ST_RESULT;
                end
                else if (stat.table_empty)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                // a quiet pass leaves the query unset, so pending proven stays 0
                if (stat.last_rule)
                begin
                    state_next = stat.fired_any ? ST_PASS : ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.out_load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !out_valid_reg || out_ready)
        else $error("output register overwritten before transfer");

    a_prove_enters_pass: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && mode == MODE_PROVE |=> state_reg == ST_PASS)
        else $error("prove item did not start a pass");

    a_scan_one_pass: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_start |=> state_reg == ST_SCAN)
        else $error("pass start did not enter scan");

endmodule

// ----- rtl/horn_forward_chaining_prover.sv -----
// Horn-clause forward-chaining prover.
// Input channel (in_valid/in_ready): mode, symbol, body_mask. Mode 0 sets
// fact "symbol", mode 1 appends rule symbol <- body_mask, mode 2 proves
// query "symbol"; mode 3 does nothing. Output channel (out_valid/out_ready)
// returns one result per item: proven (prove items only) and status (1 when
// a rule was dropped because the table holds RULE_DEPTH rules).
// Fact, rule and idle-mode items go to the result state, then into the output
// register. A prove runs passes over the stored rules: each pass checks the
// query, then reads and evaluates the rules in turn; another pass follows
// while some rule fired. A pass ends at once when the query is already a
// fact or the table is empty. The single registered read port of the rule
// table sets the pace of one rule per cycle. One item is processed at a time;
// a new item is taken as soon as the previous one has left for the output
// register. The output register holds a result until the receiver takes it;
// a stalled receiver only holds back the item behind it at its result stage.
// Reset clears the facts, the rule count, the controller state and the output
// valid flag; no clearing pass is needed. Derived facts persist across proves.
module horn_forward_chaining_prover #(
    parameter int SYMBOL_COUNT = hfcp_pkg::DEF_SYMBOL_COUNT,
    parameter int RULE_DEPTH   = hfcp_pkg::DEF_RULE_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [hfcp_pkg::MODE_W-1:0] mode,
    input  logic [hfcp_pkg::SYM_W-1:0]  symbol,
    input  logic [hfcp_pkg::BODY_W-1:0] body_mask,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        proven,
    output logic                        status
);
    import hfcp_pkg::*;

    hfcp_cmd_t  cmd;
    hfcp_stat_t stat;

    hfcp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    hfcp_datapath #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .RULE_DEPTH   (RULE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .symbol    (symbol),
        .body_mask (body_mask),
        .proven    (proven),
        .status    (status)
    );

endmodule
